// ----- rtl/dlts_pkg.sv -----
// ----------------------------------------------------------------------------
// dlts_pkg
// Types and constants shared by the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

	localparam int MAX_TASKS_DEF = 8;

	localparam logic [1:0] FN_ADD      = 2'd0;
	localparam logic [1:0] FN_DELETE   = 2'd1;
	localparam logic [1:0] FN_TICK     = 2'd2;
	localparam logic [1:0] FN_DISPATCH = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_NOT_READY  = 3'd3;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  task_handle;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
		logic [31:0] given_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] result_id;
		logic        run_valid;
		logic [7:0]  run_handle;
		logic [3:0]  task_count;
	} rsp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // latch request
		logic scan_clr;  // reset scan index and running sum
		logic scan_step; // advance scan by one entry
		logic do_insert; // insert at scan position
		logic do_remove; // remove at scan position
		logic do_tick;   // count head down
		logic take_head; // latch head for dispatch, set up reinsert
		logic fresh;     // assign fresh id
		logic set_rsp;   // latch response with given status
		logic [2:0] rsp_status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       handle_zero;
		logic       full;
		logic       empty;
		logic       head_ready;
		logic       gid_zero;
		logic       need_fresh;
		logic       scan_end;   // index reached used count
		logic       ins_hit;    // delay below running sum at index
		logic       id_hit;     // id at index matches
		logic       reinsert;   // dispatched task has a period
	} stat_t;

endpackage

// ----- rtl/dlts_datapath.sv -----
// ----------------------------------------------------------------------------
// dlts_datapath
// Task table, scan index and running sum, response register.
// ----------------------------------------------------------------------------
module dlts_datapath #(
	parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dlts_pkg::req_t  req,
	input  dlts_pkg::cmd_t  cmd,
	output dlts_pkg::stat_t stat,
	output dlts_pkg::rsp_t  rsp
);
	import dlts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [31:0] delta_q  [MAX_TASKS];
	logic [31:0] period_q [MAX_TASKS];
	logic [31:0] id_q     [MAX_TASKS];
	logic [7:0]  handle_q [MAX_TASKS];
	logic        ready_q  [MAX_TASKS];
	logic [CW-1:0] used_q;
	logic [31:0]   idc_q;
	req_t          req_q;
	logic [CW-1:0] idx_q;
	logic [32:0]   sum_q;   // absolute delay before idx
	rsp_t          rsp_q;

	logic [IW-1:0] ix;
	logic [32:0]   upto;
	logic [31:0]   idc_nx;
	logic [31:0]   ins_delta;

	assign ix        = idx_q[IW-1:0];
	assign upto      = sum_q + {1'b0, delta_q[ix]};
	assign idc_nx    = (idc_q + 32'd1 == 32'd0) ? 32'd1 : idc_q + 32'd1;
	assign ins_delta = req_q.start_delay - sum_q[31:0];

	always_comb begin
		stat.func        = req_q.func;
		stat.handle_zero = (req_q.task_handle == 8'd0);
		stat.full        = (used_q >= CW'(MAX_TASKS));
		stat.empty       = (used_q == '0);
		stat.head_ready  = ready_q[0];
		stat.gid_zero    = (req_q.given_id == 32'd0);
		stat.need_fresh  = (req_q.given_id == 32'd0);
		stat.scan_end    = (idx_q >= used_q);
		stat.ins_hit     = ({1'b0, req_q.start_delay} < upto);
		stat.id_hit      = (id_q[ix] == req_q.given_id);
		stat.reinsert    = (req_q.repeat_period != 32'd0);
	end

	assign rsp = rsp_q;

	// request, scan and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idc_q  <= '0;
			idx_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.scan_clr) begin
				idx_q <= '0;
				sum_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + CW'(1);
				sum_q <= upto;
			end
			if (cmd.fresh) idc_q <= idc_nx;
			if (cmd.do_insert) used_q <= used_q + CW'(1);
			if (cmd.do_remove) used_q <= used_q - CW'(1);
		end
	end

	// request latch; dispatch turns it into a reinsert request
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		else if (cmd.fresh) req_q.given_id <= idc_nx;
		else if (cmd.take_head) begin
			req_q.task_handle   <= handle_q[0];
			req_q.start_delay   <= period_q[0];
			req_q.repeat_period <= period_q[0];
			req_q.given_id      <= id_q[0];
		end
		if (cmd.set_rsp) begin
			rsp_q.status     <= cmd.rsp_status;
			rsp_q.result_id  <= 32'd0;
			rsp_q.run_valid  <= 1'b0;
			rsp_q.run_handle <= 8'd0;
			if (cmd.rsp_status == ST_OK && req_q.func == FN_ADD)
				rsp_q.result_id <= req_q.given_id;
		end
		if (cmd.take_head) begin
			rsp_q.status     <= ST_OK;
			rsp_q.result_id  <= id_q[0];
			rsp_q.run_valid  <= 1'b1;
			rsp_q.run_handle <= handle_q[0];
		end
		rsp_q.task_count <= 4'(used_q);
	end

	// table: shifts for insert and remove, head countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				delta_q[i]  <= '0;
				period_q[i] <= '0;
				id_q[i]     <= '0;
				handle_q[i] <= '0;
				ready_q[i]  <= 1'b0;
			end
		end else if (cmd.do_insert) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (CW'(i) > idx_q && CW'(i) <= used_q) begin
					delta_q[i]  <= delta_q[i-1];
					period_q[i] <= period_q[i-1];
					id_q[i]     <= id_q[i-1];
					handle_q[i] <= handle_q[i-1];
					ready_q[i]  <= ready_q[i-1];
				end
				if (CW'(i) == idx_q + CW'(1) && idx_q < used_q)
					delta_q[i] <= delta_q[i-1] - ins_delta;
				if (CW'(i) == idx_q) begin
					delta_q[i]  <= ins_delta;
					period_q[i] <= req_q.repeat_period;
					id_q[i]     <= req_q.given_id;
					handle_q[i] <= req_q.task_handle;
					ready_q[i]  <= (ins_delta == 32'd0);
				end
			end
		end else if (cmd.do_remove) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (CW'(i) >= idx_q && CW'(i) + CW'(1) < used_q) begin
					delta_q[i]  <= delta_q[(i+1) % MAX_TASKS];
					period_q[i] <= period_q[(i+1) % MAX_TASKS];
					id_q[i]     <= id_q[(i+1) % MAX_TASKS];
					handle_q[i] <= handle_q[(i+1) % MAX_TASKS];
					ready_q[i]  <= ready_q[(i+1) % MAX_TASKS];
					if (CW'(i) == idx_q)
						delta_q[i] <= delta_q[(i+1) % MAX_TASKS] + delta_q[i];
				end
				if (CW'(i) + CW'(1) == used_q) begin
					delta_q[i]  <= '0;
					period_q[i] <= '0;
					id_q[i]     <= '0;
					handle_q[i] <= '0;
					ready_q[i]  <= 1'b0;
				end
			end
		end else if (cmd.do_tick) begin
			if (delta_q[0] > 32'd1) delta_q[0] <= delta_q[0] - 32'd1;
			else begin
				delta_q[0] <= '0;
				ready_q[0] <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/dlts_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlts_ctrl
// Sequencer: decodes the operation and walks the table one entry a cycle.
// ----------------------------------------------------------------------------
module dlts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dlts_pkg::stat_t stat,
	output dlts_pkg::cmd_t  cmd
);
	import dlts_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DEC   = 6'b000010,
		S_ISCAN = 6'b000100,
		S_DSCAN = 6'b001000,
		S_RESP  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   reins_q, reins_d;

	assign in_ready  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		reins_d = reins_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE, S_OUT: begin
				if (in_valid && in_ready) begin
					// scan index starts at the head for every beat
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = S_DEC;
				end else if (state_q == S_OUT && out_ready) begin
					state_d = S_IDLE;
				end
			end
			S_DEC: begin
				cmd.scan_clr = 1'b1;
				reins_d      = 1'b0;
				unique case (stat.func)
					FN_ADD: begin
						if (stat.handle_zero) begin
							cmd.set_rsp = 1'b1; cmd.rsp_status = ST_BAD_HANDLE;
							state_d = S_RESP;
						end else if (stat.full) begin
							cmd.set_rsp = 1'b1; cmd.rsp_status = ST_FULL;
							state_d = S_RESP;
						end else begin
							cmd.fresh = stat.need_fresh;
							state_d   = S_ISCAN;
						end
					end
					FN_DELETE: begin
						if (stat.gid_zero) begin
							cmd.set_rsp = 1'b1; cmd.rsp_status = ST_NOT_FOUND;
							state_d = S_RESP;
						end else state_d = S_DSCAN;
					end
					FN_TICK: begin
						cmd.do_tick = !stat.empty && !stat.head_ready;
						cmd.set_rsp = 1'b1; cmd.rsp_status = ST_OK;
						state_d = S_RESP;
					end
					default: begin
						if (!stat.empty && stat.head_ready) begin
							cmd.take_head = 1'b1;
							cmd.do_remove = 1'b1;
							reins_d       = 1'b1;
							state_d       = S_RESP;
						end else begin
							cmd.set_rsp = 1'b1; cmd.rsp_status = ST_NOT_READY;
							state_d = S_RESP;
						end
					end
				endcase
			end
			S_ISCAN: begin
				if (stat.scan_end || stat.ins_hit) begin
					cmd.do_insert = 1'b1;
					if (!reins_q) begin
						cmd.set_rsp = 1'b1; cmd.rsp_status = ST_OK;
					end
					reins_d = 1'b0;
					state_d = S_RESP;
				end else cmd.scan_step = 1'b1;
			end
			S_DSCAN: begin
				if (stat.scan_end) begin
					cmd.set_rsp = 1'b1; cmd.rsp_status = ST_NOT_FOUND;
					state_d = S_RESP;
				end else if (stat.id_hit) begin
					cmd.do_remove = 1'b1;
					cmd.set_rsp = 1'b1; cmd.rsp_status = ST_OK;
					state_d = S_RESP;
				end else cmd.scan_step = 1'b1;
			end
			S_RESP: begin
				// dispatch of a periodic task goes back in through the insert scan
				if (reins_q && stat.reinsert) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_ISCAN;
				end else begin
					reins_d = 1'b0;
					// refresh count once the table has settled
					cmd.set_rsp = 1'b0;
					state_d     = S_OUT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			reins_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reins_q <= reins_d;
		end
	end

endmodule

// ----- rtl/delta_list_task_scheduler.sv -----
// Tick, errors and plain dispatch pass through the decode, response and output
// states; add and delete walk the table one entry a cycle on the way;
// a periodic dispatch adds one more insert walk. One item at a time; the next
// beat is taken in the cycle its result is taken. Reset clears the table and
// the id counter at once.
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Delta-list task scheduler: sequencer plus table datapath.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler #(
	parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dlts_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dlts_pkg::rsp_t out_data
);
	import dlts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dlts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	dlts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk, .arst_n, .req(in_data), .cmd, .stat, .rsp(out_data)
	);

endmodule
